### rtl/core/ptmmu_pkg.sv
// Shared types and codes for the page table MMU with frame replacement.
// Used by the front end, the back end and the top level; depends on nothing.
package ptmmu_pkg;

    // Input action codes
    localparam logic ACT_XLATE = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDR     = 3'd1;
    localparam logic [2:0] ST_RO       = 3'd2;
    localparam logic [2:0] ST_FAULT    = 3'd3;
    localparam logic [2:0] ST_NOVICTIM = 3'd4;

    // Field widths fixed by the stream format
    localparam int VADDR_W = 17;
    localparam int PAGE_W  = 10;
    localparam int PADDR_W = 14;
    localparam int FRAME_W = 7;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Class given to an item by the front end
    typedef enum logic [1:0] {
        KIND_XLATE,
        KIND_MAP,
        KIND_ADDR_ERR
    } kind_t;

    // Item as it travels through the queue
    typedef struct packed {
        kind_t               kind;
        logic [VADDR_W-1:0]  vaddr;
        logic                is_write;
        logic [PAGE_W-1:0]   page_number;
        logic                read_only;
    } item_t;

    // Result item
    typedef struct packed {
        logic [2:0]          status;
        logic [PADDR_W-1:0]  paddr;
        logic [FRAME_W-1:0]  frame;
        logic                evicted;
        logic [PAGE_W-1:0]   evicted_page;
    } result_t;

endpackage

### rtl/core/ptmmu_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Self-contained; holds no reset.
module ptmmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

### rtl/core/ptmmu_front.sv
// Front end: accepts items, range-checks and classifies them, and queues them.
// Depends on ptmmu_pkg.
module ptmmu_front #(
    parameter int NUM_VIRT_PAGES = 1024,
    parameter int PAGE_BYTES     = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic [ptmmu_pkg::VADDR_W-1:0]       in_vaddr,
    input  logic                                in_is_write,
    input  logic [ptmmu_pkg::PAGE_W-1:0]        in_page_number,
    input  logic                                in_read_only,
    input  logic                                clear_busy,
    output logic                                q_valid,
    output ptmmu_pkg::item_t                    q_item,
    input  logic                                q_pop
);

    localparam int OFF_W = $clog2(PAGE_BYTES);

    ptmmu_pkg::item_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [31:0]      vpn_wide;
    logic [31:0]      page_wide;
    ptmmu_pkg::item_t new_item;
    logic             push;
    logic             pop;

    // Classify the incoming item
    always_comb
    begin
        vpn_wide  = 32'(in_vaddr) >> OFF_W;
        page_wide = 32'(in_page_number);
        new_item.vaddr       = in_vaddr;
        new_item.is_write    = in_is_write;
        new_item.page_number = in_page_number;
        new_item.read_only   = in_read_only;
        if (in_action == ptmmu_pkg::ACT_MAP)
        begin
            new_item.kind = (page_wide >= 32'(NUM_VIRT_PAGES)) ? ptmmu_pkg::KIND_ADDR_ERR
                                                              : ptmmu_pkg::KIND_MAP;
        end
        else
        begin
            new_item.kind = (vpn_wide >= 32'(NUM_VIRT_PAGES)) ? ptmmu_pkg::KIND_ADDR_ERR
                                                             : ptmmu_pkg::KIND_XLATE;
        end
    end

    assign in_ready = (count_reg != 2'd2) && !clear_busy;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    // Two-entry queue toward the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= new_item;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/ptmmu_back.sv
// Back end: clears the page table after reset, then carries out translations
// and frame allocation with replacement; owns the tables and the result register.
// Depends on ptmmu_pkg and ptmmu_ram.
module ptmmu_back #(
    parameter int NUM_VIRT_PAGES = 1024,
    parameter int NUM_FRAMES     = 128,
    parameter int PAGE_BYTES     = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ptmmu_pkg::item_t     q_item,
    output logic                 q_pop,
    output logic                 clear_busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ptmmu_pkg::result_t   out_res
);

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int VPN_W  = (NUM_VIRT_PAGES > 1) ? $clog2(NUM_VIRT_PAGES) : 1;
    localparam int FRM_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int WORD_W = FRM_W + 4;
    localparam int VLD_B  = FRM_W + 3;
    localparam int RO_B   = FRM_W + 2;
    localparam int USE_B  = FRM_W + 1;
    localparam int DRT_B  = FRM_W;
    localparam logic [VPN_W-1:0] LAST_PAGE  = VPN_W'(NUM_VIRT_PAGES - 1);
    localparam logic [FRM_W-1:0] LAST_FRAME = FRM_W'(NUM_FRAMES - 1);
    localparam logic [31:0]      OFF_MASK   = 32'(PAGE_BYTES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_XLATE,
        S_FREE,
        S_VSCAN,
        S_VDONE,
        S_MAPRD,
        S_MAPWR,
        S_RESULT
    } state_t;

    state_t                        state_reg;
    ptmmu_pkg::item_t              cur_reg;
    ptmmu_pkg::result_t            res_reg;
    logic                          out_valid_reg;
    ptmmu_pkg::result_t            out_res_reg;
    logic [VPN_W-1:0]              clr_idx_reg;
    logic [FRM_W-1:0]              fidx_reg;
    logic [NUM_FRAMES-1:0]         cnt_vld_reg;
    logic [FRM_W-1:0]              f_reg;
    logic [ptmmu_pkg::COUNT_W-1:0] newcnt_reg;
    logic                          evict_reg;
    logic                          iss_on_reg;
    logic [VPN_W-1:0]              iss_idx_reg;
    logic                          p1_vld_reg;
    logic [VPN_W-1:0]              p1_idx_reg;
    logic                          p2_vld_reg;
    logic [VPN_W-1:0]              p2_idx_reg;
    logic [WORD_W-1:0]             p2_word_reg;
    logic                          have_reg;
    logic [VPN_W-1:0]              best_idx_reg;
    logic [WORD_W-1:0]             best_word_reg;
    logic [ptmmu_pkg::COUNT_W-1:0] best_cnt_reg;

    logic                          pg_we;
    logic [VPN_W-1:0]              pg_waddr;
    logic [WORD_W-1:0]             pg_wdata;
    logic [VPN_W-1:0]              pg_raddr;
    logic [WORD_W-1:0]             pg_rdata;
    logic [ptmmu_pkg::COUNT_W-1:0] cnt_rdata;
    logic                          cnt_we;

    logic [31:0]                   head_vpn32;
    logic [31:0]                   cur_vpn32;
    logic [31:0]                   map_idx32;
    logic [VPN_W-1:0]              head_vpn;
    logic [VPN_W-1:0]              cur_vpn;
    logic [VPN_W-1:0]              map_idx;
    logic [31:0]                   paddr32;
    logic [31:0]                   frame32;
    logic [31:0]                   evpage32;
    logic                          fin;
    ptmmu_pkg::result_t            fin_res;
    logic                          out_free;
    logic                          p2_elig;

    // Page table word: valid, read-only, use, dirty, frame
    ptmmu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_VIRT_PAGES)) u_page_ram (
        .clk     (clk),
        .wr_en   (pg_we),
        .wr_addr (pg_waddr),
        .wr_data (pg_wdata),
        .rd_addr (pg_raddr),
        .rd_data (pg_rdata)
    );

    // Frame use counts; cnt_vld_reg marks the frames whose entry has been written
    ptmmu_ram #(.WIDTH(ptmmu_pkg::COUNT_W), .DEPTH(NUM_FRAMES)) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (f_reg),
        .wr_data (newcnt_reg),
        .rd_addr (pg_rdata[FRM_W-1:0]),
        .rd_data (cnt_rdata)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;
    assign clear_busy = (state_reg == S_CLEAR);
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign cnt_we     = (state_reg == S_MAPRD);
    assign p2_elig    = p2_vld_reg && p2_word_reg[VLD_B] && !p2_word_reg[RO_B];

    // Derive page indexes and the physical address
    always_comb
    begin
        head_vpn32 = 32'(q_item.vaddr) >> OFF_W;
        cur_vpn32  = 32'(cur_reg.vaddr) >> OFF_W;
        map_idx32  = 32'(cur_reg.page_number);
        head_vpn   = head_vpn32[VPN_W-1:0];
        cur_vpn    = cur_vpn32[VPN_W-1:0];
        map_idx    = map_idx32[VPN_W-1:0];
        paddr32    = (32'(pg_rdata[FRM_W-1:0]) << OFF_W) | (32'(cur_reg.vaddr) & OFF_MASK);
        frame32    = 32'(f_reg);
        evpage32   = 32'(best_idx_reg);
    end

    // Drive table ports and the finished result
    always_comb
    begin
        pg_we    = 1'b0;
        pg_waddr = clr_idx_reg;
        pg_wdata = '0;
        pg_raddr = head_vpn;
        fin      = 1'b0;
        fin_res  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                pg_we = 1'b1;
            end
            S_IDLE:
            begin
                if (q_valid && q_item.kind == ptmmu_pkg::KIND_ADDR_ERR)
                begin
                    fin            = 1'b1;
                    fin_res.status = ptmmu_pkg::ST_ADDR;
                end
            end
            S_XLATE:
            begin
                fin = 1'b1;
                if (cur_reg.is_write && pg_rdata[RO_B])
                begin
                    fin_res.status = ptmmu_pkg::ST_RO;
                end
                else if (!pg_rdata[VLD_B])
                begin
                    fin_res.status = ptmmu_pkg::ST_FAULT;
                end
                else
                begin
                    fin_res.status = ptmmu_pkg::ST_OK;
                    fin_res.paddr  = paddr32[ptmmu_pkg::PADDR_W-1:0];
                    pg_we          = 1'b1;
                    pg_waddr       = cur_vpn;
                    pg_wdata       = pg_rdata;
                    pg_wdata[USE_B] = 1'b1;
                    pg_wdata[DRT_B] = pg_rdata[DRT_B] | cur_reg.is_write;
                end
            end
            S_VSCAN:
            begin
                pg_raddr = iss_idx_reg;
            end
            S_VDONE:
            begin
                if (!have_reg)
                begin
                    fin            = 1'b1;
                    fin_res.status = ptmmu_pkg::ST_NOVICTIM;
                end
                else
                begin
                    pg_we           = 1'b1;
                    pg_waddr        = best_idx_reg;
                    pg_wdata        = best_word_reg;
                    pg_wdata[VLD_B] = 1'b0;
                end
            end
            S_MAPRD:
            begin
                pg_raddr = map_idx;
            end
            S_MAPWR:
            begin
                pg_we    = 1'b1;
                pg_waddr = map_idx;
                pg_wdata = {1'b1, cur_reg.read_only, pg_rdata[USE_B], pg_rdata[DRT_B], f_reg};
                fin                  = 1'b1;
                fin_res.status       = ptmmu_pkg::ST_OK;
                fin_res.frame        = frame32[ptmmu_pkg::FRAME_W-1:0];
                fin_res.evicted      = evict_reg;
                fin_res.evicted_page = evict_reg ? evpage32[ptmmu_pkg::PAGE_W-1:0] : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            cnt_vld_reg   <= '0;
            iss_on_reg    <= 1'b0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            // Scan pipeline: page word, then the count of its frame
            p1_vld_reg  <= (state_reg == S_VSCAN) && iss_on_reg;
            p1_idx_reg  <= iss_idx_reg;
            p2_vld_reg  <= p1_vld_reg;
            p2_idx_reg  <= p1_idx_reg;
            p2_word_reg <= pg_rdata;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + VPN_W'(1);
                    if (clr_idx_reg == LAST_PAGE)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_item;
                        case (q_item.kind)
                            ptmmu_pkg::KIND_XLATE: state_reg <= S_XLATE;
                            ptmmu_pkg::KIND_MAP:
                            begin
                                fidx_reg  <= '0;
                                state_reg <= S_FREE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_FREE:
                begin
                    if (!cnt_vld_reg[fidx_reg])
                    begin
                        f_reg      <= fidx_reg;
                        newcnt_reg <= ptmmu_pkg::COUNT_W'(1);
                        evict_reg  <= 1'b0;
                        state_reg  <= S_MAPRD;
                    end
                    else if (fidx_reg == LAST_FRAME)
                    begin
                        iss_on_reg  <= 1'b1;
                        iss_idx_reg <= '0;
                        have_reg    <= 1'b0;
                        state_reg   <= S_VSCAN;
                    end
                    else
                    begin
                        fidx_reg <= fidx_reg + FRM_W'(1);
                    end
                end
                S_VSCAN:
                begin
                    if (iss_on_reg)
                    begin
                        iss_idx_reg <= iss_idx_reg + VPN_W'(1);
                        if (iss_idx_reg == LAST_PAGE)
                        begin
                            iss_on_reg <= 1'b0;
                        end
                    end
                    // Keep the first page with the strictly smallest count
                    if (p2_elig && (!have_reg || cnt_rdata < best_cnt_reg))
                    begin
                        have_reg      <= 1'b1;
                        best_idx_reg  <= p2_idx_reg;
                        best_word_reg <= p2_word_reg;
                        best_cnt_reg  <= cnt_rdata;
                    end
                    if (!iss_on_reg && !p1_vld_reg && !p2_vld_reg)
                    begin
                        state_reg <= S_VDONE;
                    end
                end
                S_VDONE:
                begin
                    if (have_reg)
                    begin
                        f_reg      <= best_word_reg[FRM_W-1:0];
                        newcnt_reg <= (best_cnt_reg == ptmmu_pkg::COUNT_MAX) ?
                                      ptmmu_pkg::COUNT_MAX :
                                      best_cnt_reg + ptmmu_pkg::COUNT_W'(1);
                        evict_reg  <= 1'b1;
                        state_reg  <= S_MAPRD;
                    end
                end
                S_MAPRD:
                begin
                    cnt_vld_reg[f_reg] <= 1'b1;
                    state_reg          <= S_MAPWR;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // Return to idle once the finished item is delivered, else hold it
            if (fin)
            begin
                if (out_free)
                begin
                    state_reg <= S_IDLE;
                end
                else
                begin
                    res_reg   <= fin_res;
                    state_reg <= S_RESULT;
                end
            end

            // Load the output register, or drop the item the sink took
            if (fin && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= fin_res;
            end
            else if (state_reg == S_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/page_table_mmu_with_frame_replacement_top.sv
// Top level of the page table MMU with frame replacement: stream ports,
// field packing, front end and back end. Depends on ptmmu_pkg, ptmmu_front, ptmmu_back.
//
// After reset the block clears its page table, one entry per cycle, and
// accepts no item meanwhile. A translation reads the page table, then
// checks and updates the entry. A map looks for a frame that was never used
// (one frame per cycle) and then updates the tables; when no frame is
// free it also scans the page table for a victim, one page per cycle through
// a read pipeline of page word and then frame count. Items with an
// out-of-range page finish straight from the idle state. A two-entry queue
// and the output register let the input side run ahead of a stalled output.
module page_table_mmu_with_frame_replacement_top #(
    parameter int NUM_VIRT_PAGES = 1024,
    parameter int NUM_FRAMES     = 128,
    parameter int PAGE_BYTES     = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // vaddr[16:0], is_write, page_number[9:0], map_read_only
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[2:0], paddr[13:0], frame[6:0], evicted,
                                        // evicted_page[9:0]
);

    logic               q_valid;
    ptmmu_pkg::item_t   q_item;
    logic               q_pop;
    logic               clear_busy;
    ptmmu_pkg::result_t res;

    ptmmu_front #(
        .NUM_VIRT_PAGES (NUM_VIRT_PAGES),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_action      (s_axis_tuser[0]),
        .in_vaddr       (s_axis_tdata[16:0]),
        .in_is_write    (s_axis_tdata[17]),
        .in_page_number (s_axis_tdata[27:18]),
        .in_read_only   (s_axis_tdata[28]),
        .clear_busy     (clear_busy),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    ptmmu_back #(
        .NUM_VIRT_PAGES (NUM_VIRT_PAGES),
        .NUM_FRAMES     (NUM_FRAMES),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    // Pack the result item
    assign m_axis_tdata = {5'd0, res.evicted_page, res.evicted, res.frame,
                           res.paddr, res.status};

endmodule

### tb/tb_page_table_mmu_with_frame_replacement_top.sv
// Testbench for page_table_mmu_with_frame_replacement_top: drives translate and map
// items over the input stream and checks each result item against a local page table model.
// Depends on ptmmu_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_page_table_mmu_with_frame_replacement_top;

    localparam int NUM_PAGES  = 1024;
    localparam int NUM_FRMS   = 128;
    localparam int PG_BYTES   = 128;
    localparam int CYCLE_LIMIT = 3000000;

    // Page table model with a queue of expected result items
    class mmu_scoreboard;
        bit                            pg_valid [NUM_PAGES];
        bit                            pg_ro    [NUM_PAGES];
        bit                            pg_use   [NUM_PAGES];
        bit                            pg_dirty [NUM_PAGES];
        logic [ptmmu_pkg::FRAME_W-1:0] pg_frame [NUM_PAGES];
        logic [ptmmu_pkg::COUNT_W-1:0] frm_count[NUM_FRMS];
        ptmmu_pkg::result_t            expected_q[$];
        int                            errors;

        function new();
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                pg_valid[i] = 0;
                pg_ro[i]    = 0;
                pg_use[i]   = 0;
                pg_dirty[i] = 0;
                pg_frame[i] = '0;
            end
            for (int f = 0; f < NUM_FRMS; f++)
                frm_count[f] = '0;
            errors = 0;
        endfunction

        // Predict the result of one accepted item and update the table
        function void note_input(logic act, logic [ptmmu_pkg::VADDR_W-1:0] va, logic wr,
                                 logic [ptmmu_pkg::PAGE_W-1:0] pg, logic ro);
            ptmmu_pkg::result_t r;
            int      vpn;
            int      off;
            int      f;
            int      best;
            bit      found;
            bit      have;
            r = '0;
            if (act == ptmmu_pkg::ACT_XLATE)
            begin
                vpn = va / PG_BYTES;
                off = va % PG_BYTES;
                if (vpn >= NUM_PAGES)
                    r.status = ptmmu_pkg::ST_ADDR;
                else if (wr && pg_ro[vpn])
                    r.status = ptmmu_pkg::ST_RO;
                else if (!pg_valid[vpn])
                    r.status = ptmmu_pkg::ST_FAULT;
                else
                begin
                    r.status = ptmmu_pkg::ST_OK;
                    pg_use[vpn] = 1;
                    if (wr)
                        pg_dirty[vpn] = 1;
                    r.paddr = ptmmu_pkg::PADDR_W'(pg_frame[vpn] * PG_BYTES + off);
                end
            end
            else if (pg >= NUM_PAGES)
                r.status = ptmmu_pkg::ST_ADDR;
            else
            begin
                found = 0;
                f = 0;
                // take the lowest frame that was never used
                for (int i = 0; i < NUM_FRMS && !found; i++)
                    if (frm_count[i] == 0)
                    begin
                        found = 1;
                        f = i;
                    end
                // otherwise evict the first writable page on the least used frame
                if (!found)
                begin
                    have = 0;
                    best = 0;
                    for (int i = 0; i < NUM_PAGES; i++)
                        if (pg_valid[i] && !pg_ro[i])
                            if (!have || frm_count[pg_frame[i]] < frm_count[pg_frame[best]])
                            begin
                                best = i;
                                have = 1;
                            end
                    if (have)
                    begin
                        pg_valid[best]  = 0;
                        f               = pg_frame[best];
                        r.evicted       = 1;
                        r.evicted_page  = ptmmu_pkg::PAGE_W'(best);
                        found           = 1;
                    end
                end
                if (!found)
                    r.status = ptmmu_pkg::ST_NOVICTIM;
                else
                begin
                    r.status = ptmmu_pkg::ST_OK;
                    if (frm_count[f] != ptmmu_pkg::COUNT_MAX)
                        frm_count[f]++;
                    pg_frame[pg] = ptmmu_pkg::FRAME_W'(f);
                    pg_valid[pg] = 1;
                    pg_ro[pg]    = ro;
                    r.frame      = ptmmu_pkg::FRAME_W'(f);
                end
            end
            expected_q = {expected_q, r};
        endfunction

        // Compare a result item with the oldest expectation
        function void check_result(ptmmu_pkg::result_t got);
            ptmmu_pkg::result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.paddr !== exp_r.paddr ||
                got.frame !== exp_r.frame || got.evicted !== exp_r.evicted ||
                got.evicted_page !== exp_r.evicted_page)
            begin
                $display("%0t: expected status %0d paddr %h frame %0d evicted %0d page %0d",
                         $time, exp_r.status, exp_r.paddr, exp_r.frame, exp_r.evicted,
                         exp_r.evicted_page);
                $display("%0t: actual   status %0d paddr %h frame %0d evicted %0d page %0d",
                         $time, got.status, got.paddr, got.frame, got.evicted,
                         got.evicted_page);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // vaddr[16:0], is_write, page_number[9:0], map_read_only
    logic [0:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status[2:0], paddr[13:0], frame[6:0], evicted,
                                 // evicted_page[9:0]

    mmu_scoreboard sb;
    int            send_idle;
    int            recv_idle;
    int            cycles;

    page_table_mmu_with_frame_replacement_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Split the output bus into result fields, lowest bits first
    function automatic ptmmu_pkg::result_t unpack_result(logic [39:0] d);
        ptmmu_pkg::result_t r;
        r.status       = d[2:0];
        r.paddr        = d[16:3];
        r.frame        = d[23:17];
        r.evicted      = d[24];
        r.evicted_page = d[34:25];
        return r;
    endfunction

    always #6 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // Check each accepted result item
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(unpack_result(m_axis_tdata));

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("page_table_mmu_with_frame_replacement_top: mismatch");
            $finish;
        end
    end

    // Present one item, with random idle cycles ahead, and hold it until accepted
    task automatic send_item(logic act, logic [ptmmu_pkg::VADDR_W-1:0] va, logic wr,
                             logic [ptmmu_pkg::PAGE_W-1:0] pg, logic ro);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, ro, pg, wr, va};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(act, va, wr, pg, ro);
    endtask

    // Pages mostly from a small working set so translations hit
    function automatic logic [ptmmu_pkg::PAGE_W-1:0] pick_page();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return ptmmu_pkg::PAGE_W'($urandom_range(47));
        else if (p < 80)
            return ptmmu_pkg::PAGE_W'(NUM_PAGES - 1);
        return ptmmu_pkg::PAGE_W'($urandom);
    endfunction

    // Random items: map_pct of them maps, ro_pct of maps read-only
    task automatic random_items(int n, int map_pct, int ro_pct);
        logic [ptmmu_pkg::VADDR_W-1:0] va;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                va = ptmmu_pkg::VADDR_W'($urandom);
            else
                va = {pick_page(), 7'($urandom)};
            send_item(($urandom_range(99) < map_pct) ? ptmmu_pkg::ACT_MAP : ptmmu_pkg::ACT_XLATE,
                      va, 1'($urandom), pick_page(), ($urandom_range(99) < ro_pct));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold until every expected result has arrived
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cycles        = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        send_idle     = 25;
        recv_idle     = 76;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: faults on an empty table, extreme addresses, maps, permissions
        send_item(ptmmu_pkg::ACT_XLATE, 17'd0, 1'b0, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'h1FFFF, 1'b1, 10'h3FF, 1'b1);
        send_item(ptmmu_pkg::ACT_MAP, 17'h1FFFF, 1'b1, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_MAP, 17'd0, 1'b0, 10'h3FF, 1'b1);
        send_item(ptmmu_pkg::ACT_XLATE, 17'h1FFFF, 1'b1, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'h1FFFF, 1'b0, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd0, 1'b1, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd127, 1'b0, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_MAP, 17'd0, 1'b0, 10'd0, 1'b1);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd5, 1'b1, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd5, 1'b0, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_MAP, 17'd0, 1'b0, 10'd1, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd200, 1'b1, 10'd0, 1'b0);
        send_item(ptmmu_pkg::ACT_XLATE, 17'd256, 1'b0, 10'd0, 1'b0);

        // Mixed traffic, sender idles less than receiver
        random_items(130, 35, 30);
        drain();

        // More maps to fill every frame and start evicting
        send_idle = 76;
        recv_idle = 25;
        random_items(150, 55, 30);
        drain();

        // Read-only maps until writable victims run out
        send_idle = 0;
        recv_idle = 0;
        random_items(170, 85, 90);
        drain();

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("page_table_mmu_with_frame_replacement_top: match");
        else
            $display("page_table_mmu_with_frame_replacement_top: mismatch");
        $finish;
    end

endmodule
